// ----- hdl/pngc_pkg.sv -----
// ----------------------------------------------------------------------------
// pngc_pkg
// Shared types, codes and helper functions of the pixel format converter.
// ----------------------------------------------------------------------------
`default_nettype none
package pngc_pkg;

   localparam int PALETTE_ENTRIES_DEFAULT = 256;

   localparam logic [2:0] CT_GRAY  = 3'd0;
   localparam logic [2:0] CT_RGB   = 3'd2;
   localparam logic [2:0] CT_INDEX = 3'd3;
   localparam logic [2:0] CT_GA    = 3'd4;
   localparam logic [2:0] CT_RGBA  = 3'd6;

   localparam logic [2:0] REG_SRC_TYPE  = 3'd0;
   localparam logic [2:0] REG_SRC_DEPTH = 3'd1;
   localparam logic [2:0] REG_DST_TYPE  = 3'd2;
   localparam logic [2:0] REG_DST_DEPTH = 3'd3;
   localparam logic [2:0] REG_PAL_COUNT = 3'd4;
   localparam logic [2:0] REG_ALP_COUNT = 3'd5;

   localparam logic [17:0] GRAY_THRESHOLD = 18'h18000;
   localparam logic [9:0]  SCORE_INIT     = 10'd1023;

   typedef struct packed {
      logic        mode;
      logic [63:0] sample_in;
      logic [7:0]  entry_index;
      logic [7:0]  entry_red;
      logic [7:0]  entry_green;
      logic [7:0]  entry_blue;
      logic [7:0]  entry_alpha;
   } req_type;

   typedef struct packed {
      logic [63:0] sample_out;
      logic        bad_format;
   } rsp_type;

   // Classified conversion job handed from the front part to the back part.
   typedef struct packed {
      logic        bad;
      logic [15:0] r;
      logic [15:0] g;
      logic [15:0] b;
      logic [15:0] a;
   } job_type;

   function automatic logic pair_ok(input logic [2:0] t, input logic [4:0] d);
      logic wide;
      logic narrow;
      begin
         wide   = (d == 5'd8) || (d == 5'd16);
         narrow = (d == 5'd1) || (d == 5'd2) || (d == 5'd4) || (d == 5'd8);
         case (t)
            CT_GRAY:  pair_ok = narrow || (d == 5'd16);
            CT_INDEX: pair_ok = narrow;
            CT_RGB, CT_GA, CT_RGBA: pair_ok = wide;
            default:  pair_ok = 1'b0;
         endcase
      end
   endfunction

   function automatic logic [15:0] rep8(input logic [7:0] v);
      rep8 = {v, v};
   endfunction

   function automatic logic [7:0] absdiff(input logic [7:0] x, input logic [7:0] y);
      absdiff = (x > y) ? (x - y) : (y - x);
   endfunction

endpackage
`default_nettype wire

// ----- hdl/pngc_front.sv -----
// ----------------------------------------------------------------------------
// pngc_front
// Accepts items, writes palette loads and expands pixels to 16-bit RGBA.
// ----------------------------------------------------------------------------
`default_nettype none
module pngc_front #(
   parameter int PALETTE_ENTRIES = pngc_pkg::PALETTE_ENTRIES_DEFAULT,
   localparam int IW = $clog2(PALETTE_ENTRIES),
   localparam int CW = $clog2(PALETTE_ENTRIES + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pngc_pkg::req_type req_data,
   input  wire logic [2:0]        src_type,
   input  wire logic [4:0]        src_depth,
   input  wire logic              dst_ok,
   input  wire logic [CW-1:0]     pal_cnt,
   input  wire logic [CW-1:0]     alp_cnt,
   input  wire logic              back_busy,
   output logic                   job_valid,
   input  wire logic              job_ready,
   output pngc_pkg::job_type      job_data,
   output logic                   pal_we,
   output logic [IW-1:0]          pal_waddr,
   output logic [31:0]            pal_wdata
);
   // Stage 1 reads the palette for indexed sources; stage 2 forms the RGBA job.
   logic              s1_valid_ff, s1_valid_in;
   logic [63:0]       s1_sample_ff;
   logic              s1_bad_ff;
   logic              s1_col_ff, s1_alp_ff;
   logic [31:0]       s1_entry_ff;
   logic [31:0]       mem [PALETTE_ENTRIES];
   logic [7:0]        ix;
   logic [15:0]       idx_mask;
   logic              stall;
   logic              load_hold;
   logic [15:0]       gray;
   logic [2:0]        dsel;

   assign stall     = s1_valid_ff && !job_ready;
   // A load waits until no pixel is in flight, so that the back part's palette
   // copy never changes under a search of an earlier pixel.
   assign load_hold = req_data.mode && (s1_valid_ff || back_busy);
   assign req_ready = !stall && !load_hold;
   assign idx_mask  = (16'd1 << src_depth[3:0]) - 16'd1;
   assign ix        = req_data.sample_in[7:0] & idx_mask[7:0];
   assign s1_valid_in = (req_valid && req_ready && !req_data.mode) || stall;

   assign pal_we    = req_valid && req_ready && req_data.mode &&
                      ({1'b0, req_data.entry_index} < 9'(PALETTE_ENTRIES));
   assign pal_waddr = req_data.entry_index[IW-1:0];
   assign pal_wdata = {req_data.entry_red, req_data.entry_green,
                       req_data.entry_blue, req_data.entry_alpha};

   always_ff @(posedge clock) begin
      if (pal_we) begin
         mem[pal_waddr] <= pal_wdata;
      end
      if (!stall) begin
         s1_entry_ff  <= mem[ix[IW-1:0]];
         s1_sample_ff <= req_data.sample_in;
         s1_bad_ff    <= !pngc_pkg::pair_ok(src_type, src_depth) || !dst_ok;
         s1_col_ff    <= ({1'b0, ix} < 9'(pal_cnt));
         s1_alp_ff    <= ({1'b0, ix} < 9'(alp_cnt));
      end
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_comb begin
      logic [15:0] v;
      v = s1_sample_ff[15:0] & idx_mask;
      dsel = src_depth[2:0];
      case (src_depth)
         5'd1:    gray = v[0] ? 16'hffff : 16'h0000;
         5'd2:    gray = {8{v[1:0]}};
         5'd4:    gray = {4{v[3:0]}};
         5'd8:    gray = pngc_pkg::rep8(v[7:0]);
         default: gray = s1_sample_ff[15:0];
      endcase
   end

   always_comb begin
      logic w8;
      w8 = (src_depth == 5'd8);
      job_data.bad = s1_bad_ff;
      job_data.a   = 16'hffff;
      case (src_type)
         pngc_pkg::CT_GRAY: begin
            job_data.r = gray; job_data.g = gray; job_data.b = gray;
         end
         pngc_pkg::CT_RGB: begin
            job_data.r = w8 ? pngc_pkg::rep8(s1_sample_ff[23:16]) : s1_sample_ff[47:32];
            job_data.g = w8 ? pngc_pkg::rep8(s1_sample_ff[15:8])  : s1_sample_ff[31:16];
            job_data.b = w8 ? pngc_pkg::rep8(s1_sample_ff[7:0])   : s1_sample_ff[15:0];
         end
         pngc_pkg::CT_INDEX: begin
            job_data.r = s1_col_ff ? pngc_pkg::rep8(s1_entry_ff[31:24]) : 16'h0;
            job_data.g = s1_col_ff ? pngc_pkg::rep8(s1_entry_ff[23:16]) : 16'h0;
            job_data.b = s1_col_ff ? pngc_pkg::rep8(s1_entry_ff[15:8])  : 16'h0;
            if (s1_alp_ff) job_data.a = pngc_pkg::rep8(s1_entry_ff[7:0]);
         end
         pngc_pkg::CT_GA: begin
            job_data.r = w8 ? pngc_pkg::rep8(s1_sample_ff[15:8]) : s1_sample_ff[31:16];
            job_data.g = job_data.r; job_data.b = job_data.r;
            job_data.a = w8 ? pngc_pkg::rep8(s1_sample_ff[7:0]) : s1_sample_ff[15:0];
         end
         default: begin
            job_data.r = w8 ? pngc_pkg::rep8(s1_sample_ff[31:24]) : s1_sample_ff[63:48];
            job_data.g = w8 ? pngc_pkg::rep8(s1_sample_ff[23:16]) : s1_sample_ff[47:32];
            job_data.b = w8 ? pngc_pkg::rep8(s1_sample_ff[15:8])  : s1_sample_ff[31:16];
            job_data.a = w8 ? pngc_pkg::rep8(s1_sample_ff[7:0])   : s1_sample_ff[15:0];
         end
      endcase
      if (dsel == 3'd7) job_data.bad = 1'b1;
   end

   assign job_valid = s1_valid_ff;
endmodule
`default_nettype wire

// ----- hdl/pngc_queue.sv -----
// ----------------------------------------------------------------------------
// pngc_queue
// Two-entry queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
`default_nettype none
module pngc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire pngc_pkg::job_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output pngc_pkg::job_type      out_data
);
   pngc_pkg::job_type slot_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = slot_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= in_data;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

// ----- hdl/pngc_back.sv -----
// ----------------------------------------------------------------------------
// pngc_back
// Encodes RGBA jobs into the destination format, with a sequential
// nearest-palette search that visits one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pngc_back #(
   parameter int PALETTE_ENTRIES = pngc_pkg::PALETTE_ENTRIES_DEFAULT,
   localparam int IW = $clog2(PALETTE_ENTRIES),
   localparam int CW = $clog2(PALETTE_ENTRIES + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   output logic                   job_ready,
   input  wire pngc_pkg::job_type job_data,
   input  wire logic [2:0]        dst_type,
   input  wire logic [4:0]        dst_depth,
   input  wire logic [CW-1:0]     pal_cnt,
   input  wire logic [CW-1:0]     alp_cnt,
   input  wire logic              pal_we,
   input  wire logic [IW-1:0]     pal_waddr,
   input  wire logic [31:0]       pal_wdata,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pngc_pkg::rsp_type      rsp_data
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LUMA = 2'd1;
   localparam logic [1:0] ST_SRCH = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]        st_ff;
   pngc_pkg::job_type job_ff;
   logic [17:0]       sum_ff;
   logic [15:0]       luma_ff;
   logic [CW-1:0]     ix_ff;
   logic [IW-1:0]     best_ff;
   logic [9:0]        score_ff;
   logic              hit_ff;
   logic              rd_ok_ff;
   logic [CW-1:0]     rd_ix_ff;
   logic [31:0]       ent_ff;
   logic [31:0]       mem [PALETTE_ENTRIES];
   logic              out_valid_ff;
   pngc_pkg::rsp_type out_ff;
   logic [63:0]       enc;
   logic [9:0]        score;
   logic [7:0]        ea;
   logic [15:0]       dmask;
   logic [3:0]        dshift;
   logic [16:0]       luma_full;

   assign job_ready = (st_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign dmask  = (16'd1 << dst_depth[3:0]) - 16'd1;
   assign dshift = 4'(5'd16 - dst_depth);
   // Divide by three through a reciprocal: 174763 / 2^19 is exact for 18 bits.
   assign luma_full = 17'((36'(sum_ff) * 36'd174763) >> 19);

   assign ea = ({1'b0, rd_ix_ff} < 10'(alp_cnt)) ? ent_ff[7:0] : 8'hff;
   assign score = 10'(pngc_pkg::absdiff(ent_ff[31:24], job_ff.r[15:8]))
                + 10'(pngc_pkg::absdiff(ent_ff[23:16], job_ff.g[15:8]))
                + 10'(pngc_pkg::absdiff(ent_ff[15:8],  job_ff.b[15:8]))
                + 10'(pngc_pkg::absdiff(ea, job_ff.a[15:8]));

   always_comb begin
      logic w8;
      logic [15:0] l;
      w8 = (dst_depth == 5'd8);
      l  = luma_ff;
      case (dst_type)
         pngc_pkg::CT_GRAY:
            enc = (dst_depth == 5'd1) ? {63'd0, sum_ff >= pngc_pkg::GRAY_THRESHOLD}
                                      : {48'd0, l >> dshift};
         pngc_pkg::CT_RGB:
            enc = w8 ? {40'd0, job_ff.r[15:8], job_ff.g[15:8], job_ff.b[15:8]}
                     : {16'd0, job_ff.r, job_ff.g, job_ff.b};
         pngc_pkg::CT_INDEX:
            enc = (pal_cnt == '0) ? {48'd0, (l >> dshift) & dmask}
                                  : {48'd0, 16'(best_ff) & dmask};
         pngc_pkg::CT_GA:
            enc = w8 ? {48'd0, l[15:8], job_ff.a[15:8]} : {32'd0, l, job_ff.a};
         default:
            enc = w8 ? {32'd0, job_ff.r[15:8], job_ff.g[15:8], job_ff.b[15:8],
                        job_ff.a[15:8]}
                     : {job_ff.r, job_ff.g, job_ff.b, job_ff.a};
      endcase
   end

   always_ff @(posedge clock) begin
      if (pal_we) mem[pal_waddr] <= pal_wdata;
      ent_ff   <= mem[ix_ff[IW-1:0]];
      rd_ix_ff <= ix_ff;
      if (st_ff == ST_IDLE && job_valid) begin
         job_ff <= job_data;
         sum_ff <= 18'(job_data.r) + 18'(job_data.g) + 18'(job_data.b);
      end
      if (st_ff == ST_LUMA) begin
         luma_ff  <= luma_full[15:0];
         best_ff  <= '0;
         score_ff <= pngc_pkg::SCORE_INIT;
         hit_ff   <= 1'b0;
      end
      if (st_ff == ST_SRCH && rd_ok_ff && !hit_ff && score < score_ff) begin
         best_ff  <= rd_ix_ff[IW-1:0];
         score_ff <= score;
         hit_ff   <= (score == 10'd0);
      end
      if (st_ff == ST_OUT && (!out_valid_ff || rsp_ready)) begin
         out_ff.bad_format <= job_ff.bad;
         out_ff.sample_out <= job_ff.bad ? 64'd0 : enc;
      end
      if (reset) begin
         st_ff <= ST_IDLE; out_valid_ff <= 1'b0; ix_ff <= '0; rd_ok_ff <= 1'b0;
      end else begin
         if (st_ff == ST_OUT && (!out_valid_ff || rsp_ready)) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
         case (st_ff)
            ST_IDLE: if (job_valid) st_ff <= ST_LUMA;
            ST_LUMA: begin
               ix_ff    <= '0;
               rd_ok_ff <= 1'b0;
               st_ff    <= (!job_ff.bad && dst_type == pngc_pkg::CT_INDEX &&
                            pal_cnt != '0) ? ST_SRCH : ST_OUT;
            end
            ST_SRCH: begin
               // Entry ix_ff is read this cycle and scored the next.
               rd_ok_ff <= (ix_ff < pal_cnt);
               if (ix_ff < pal_cnt) ix_ff <= ix_ff + 1'b1;
               if (rd_ok_ff == 1'b0 && ix_ff != '0) st_ff <= ST_OUT;
            end
            ST_OUT: if (!out_valid_ff || rsp_ready) st_ff <= ST_IDLE;
            default: st_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- hdl/png_pixel_format_converter.sv -----
// ----------------------------------------------------------------------------
// png_pixel_format_converter
// Converts one pixel code between PNG pixel formats and loads palette entries.
// ----------------------------------------------------------------------------
// Items enter on the req_ channel (valid/ready). A load item (mode 1) writes
// one palette entry and produces no result. A convert item (mode 0) produces
// exactly one result item on the rsp_ channel, in order.
// The front part reads the palette and expands the pixel to 16-bit RGBA; the
// back part computes the luma in its LUMA state and encodes. For a non-indexed
// target the back part passes through its IDLE, LUMA and OUT states, and it
// takes no new item until it is back in IDLE. An indexed target adds a search
// that scores one palette entry per cycle, set by the single read port of the
// back-part palette copy. A load item waits at the input until no pixel is in
// flight, so that a search always sees the palette of its own pixel.
// A two-entry queue sits between the parts so that the front keeps accepting
// while the back searches. When the receiver stalls, the result holds in its
// output register, the queue fills, and req_ready then drops.
// Reset (synchronous, active high) empties the pipeline and restores the
// registers to their reset values; the palette is undefined until loaded.
// Configuration writes use csr_write, csr_index and csr_data while idle.
// ----------------------------------------------------------------------------
`default_nettype none
module png_pixel_format_converter #(
   parameter int PALETTE_ENTRIES = pngc_pkg::PALETTE_ENTRIES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pngc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pngc_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write,
   input  wire logic [2:0]        csr_index,
   input  wire logic [8:0]        csr_data
);
   localparam int IW = $clog2(PALETTE_ENTRIES);
   localparam int CW = $clog2(PALETTE_ENTRIES + 1);

   logic [2:0] src_type_ff, dst_type_ff;
   logic [4:0] src_depth_ff, dst_depth_ff;
   logic [8:0] pal_raw_ff, alp_raw_ff;
   logic [CW-1:0] pal_cnt, alp_cnt;

   // Counts beyond the palette size saturate.
   assign pal_cnt = (pal_raw_ff > 9'(PALETTE_ENTRIES)) ? CW'(PALETTE_ENTRIES)
                                                      : pal_raw_ff[CW-1:0];
   assign alp_cnt = (alp_raw_ff > 9'(PALETTE_ENTRIES)) ? CW'(PALETTE_ENTRIES)
                                                      : alp_raw_ff[CW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         src_type_ff <= pngc_pkg::CT_RGBA; src_depth_ff <= 5'd8;
         dst_type_ff <= pngc_pkg::CT_RGBA; dst_depth_ff <= 5'd8;
         pal_raw_ff  <= 9'd0;              alp_raw_ff   <= 9'd0;
      end else if (csr_write) begin
         case (csr_index)
            pngc_pkg::REG_SRC_TYPE:  src_type_ff  <= csr_data[2:0];
            pngc_pkg::REG_SRC_DEPTH: src_depth_ff <= csr_data[4:0];
            pngc_pkg::REG_DST_TYPE:  dst_type_ff  <= csr_data[2:0];
            pngc_pkg::REG_DST_DEPTH: dst_depth_ff <= csr_data[4:0];
            pngc_pkg::REG_PAL_COUNT: pal_raw_ff   <= csr_data;
            pngc_pkg::REG_ALP_COUNT: alp_raw_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   logic              f_valid, f_ready, b_valid, b_ready;
   pngc_pkg::job_type f_data, b_data;
   logic              pal_we;
   logic [IW-1:0]     pal_waddr;
   logic [31:0]       pal_wdata;

   pngc_front #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .src_type(src_type_ff), .src_depth(src_depth_ff),
      .dst_ok(pngc_pkg::pair_ok(dst_type_ff, dst_depth_ff)),
      .pal_cnt, .alp_cnt,
      .back_busy(b_valid || !b_ready),
      .job_valid(f_valid), .job_ready(f_ready), .job_data(f_data),
      .pal_we, .pal_waddr, .pal_wdata
   );

   pngc_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
   );

   pngc_back #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_back (
      .clock, .reset,
      .job_valid(b_valid), .job_ready(b_ready), .job_data(b_data),
      .dst_type(dst_type_ff), .dst_depth(dst_depth_ff),
      .pal_cnt, .alp_cnt, .pal_we, .pal_waddr, .pal_wdata,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   // A result marked bad carries an all-zero sample.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_format |-> rsp_data.sample_out == 64'd0)
      else $error("bad format result with nonzero sample");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // A pixel item stalls only when the queue is full.
   a_front_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_data.mode && !req_ready |-> f_valid && !f_ready)
      else $error("input stalled without back pressure");
endmodule
`default_nettype wire
